/* rtl/cdr_pkg.sv */
// ---------------------------------------------------------------------------
// cdr_pkg: shared types and constants of the declaration recognizer
// Payload structs, parse phases, register indexes and byte class helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package cdr_pkg;

   localparam int LEN_W = 7;
   localparam logic [LEN_W-1:0] LEN_SAT = 7'd127;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_MIN_FRAG_LEN = 2'd0;
   localparam logic [1:0] CSR_MAX_FRAG_LEN = 2'd1;
   localparam logic [1:0] CSR_MAX_TOK_LEN  = 2'd2;

   localparam logic [LEN_W-1:0] MIN_FRAG_LEN_RST = 7'd6;
   localparam logic [LEN_W-1:0] MAX_FRAG_LEN_RST = 7'd96;
   localparam logic [LEN_W-1:0] MAX_TOK_LEN_RST  = 7'd64;

   localparam logic [6:0] CONF_ONE_MARK  = 7'd82;
   localparam logic [6:0] CONF_TWO_MARKS = 7'd88;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_TYPE,
      PH_SEP,
      PH_MARKS,
      PH_GAP,
      PH_IDENT,
      PH_TRAIL
   } cdr_phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } cdr_req_type;

   typedef struct packed {
      logic       is_declaration;
      logic [1:0] pointer_level;
      logic [6:0] confidence_percent;
   } cdr_rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] min_fragment_length;
      logic [LEN_W-1:0] max_fragment_length;
      logic [LEN_W-1:0] max_token_length;
   } cdr_cfg_type;

   typedef struct packed {
      cdr_phase_type    phase;
      logic [LEN_W-1:0] trimmed_length;
      logic [LEN_W-1:0] trailing_blank_run;
      logic [LEN_W-1:0] token_length;
      logic [1:0]       mark_count;
      logic             saw_letter;
      logic [7:0]       previous_byte;
      logic             rejected;
   } cdr_state_type;

   localparam cdr_state_type STATE_RST = '{
      phase:              PH_LEAD,
      trimmed_length:     '0,
      trailing_blank_run: '0,
      token_length:       '0,
      mark_count:         '0,
      saw_letter:         1'b0,
      previous_byte:      '0,
      rejected:           1'b0
   };

   function automatic logic is_trim_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_sep_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic is_mark(input logic [7:0] c);
      return (c == CH_AMP) || (c == CH_STAR);
   endfunction

   function automatic logic is_ident_start(input logic [7:0] c);
      return is_letter(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      return is_ident_start(c) || is_digit(c);
   endfunction

   // { } [ ] ( ) ; = ,
   function automatic logic is_forbidden(input logic [7:0] c);
      return (c == 8'h7B) || (c == 8'h7D) || (c == 8'h5B) || (c == 8'h5D) ||
             (c == 8'h28) || (c == 8'h29) || (c == 8'h3B) || (c == CH_EQ) ||
             (c == 8'h2C);
   endfunction

   function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] a);
      return (a == LEN_SAT) ? LEN_SAT : a + 7'd1;
   endfunction

   function automatic logic [LEN_W-1:0] sat_sum(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      logic [LEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_W] ? LEN_SAT : s[LEN_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/cdr_csr.sv */
// ---------------------------------------------------------------------------
// cdr_csr: configuration registers
// Holds the fragment and token length limits; writes to unused indexes drop.
// ---------------------------------------------------------------------------
`default_nettype none

module cdr_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [cdr_pkg::LEN_W-1:0] csr_data,
   output cdr_pkg::cdr_cfg_type           cfg
);

   cdr_pkg::cdr_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cdr_pkg::CSR_MIN_FRAG_LEN: cfg_in.min_fragment_length = csr_data;
            cdr_pkg::CSR_MAX_FRAG_LEN: cfg_in.max_fragment_length = csr_data;
            cdr_pkg::CSR_MAX_TOK_LEN:  cfg_in.max_token_length    = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_fragment_length <= cdr_pkg::MIN_FRAG_LEN_RST;
         cfg_ff.max_fragment_length <= cdr_pkg::MAX_FRAG_LEN_RST;
         cfg_ff.max_token_length    <= cdr_pkg::MAX_TOK_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/cdr_step.sv */
// ---------------------------------------------------------------------------
// cdr_step: per-byte next-state and verdict logic
// Advances the parse phase, running lengths and reject flag for one byte.
// ---------------------------------------------------------------------------
`default_nettype none

module cdr_step (
   input  wire cdr_pkg::cdr_state_type state,
   input  wire cdr_pkg::cdr_cfg_type   cfg,
   input  wire cdr_pkg::cdr_req_type   req,
   output cdr_pkg::cdr_state_type      state_nxt,
   output cdr_pkg::cdr_rsp_type        rsp
);

   logic [7:0]                c;
   logic                      blank;
   logic                      grow;
   logic                      grow_from_zero;
   logic                      type_check;
   logic [cdr_pkg::LEN_W-1:0] tok_new;
   logic [cdr_pkg::LEN_W-1:0] run_inc;
   logic                      ok;
   cdr_pkg::cdr_state_type    nx;

   assign c     = req.ch;
   assign blank = cdr_pkg::is_trim_blank(c);

   always_comb begin
      nx             = state;
      grow           = 1'b0;
      grow_from_zero = 1'b0;
      type_check     = 1'b0;
      tok_new        = '0;
      run_inc        = cdr_pkg::sat_inc(state.trailing_blank_run);

      if (cdr_pkg::is_forbidden(c))
         nx.rejected = 1'b1;
      if ((state.previous_byte == cdr_pkg::CH_COLON && c == cdr_pkg::CH_COLON) ||
          (state.previous_byte == cdr_pkg::CH_DASH  && c == cdr_pkg::CH_GT) ||
          (state.previous_byte == cdr_pkg::CH_EQ    && c == cdr_pkg::CH_GT))
         nx.rejected = 1'b1;

      // Trim: blanks count only once a non-blank follows them
      if (state.phase != cdr_pkg::PH_LEAD || !blank) begin
         if (blank) begin
            nx.trailing_blank_run = run_inc;
         end else begin
            nx.trimmed_length     = cdr_pkg::sat_sum(state.trimmed_length, run_inc);
            nx.trailing_blank_run = '0;
         end
      end

      unique case (state.phase)
         cdr_pkg::PH_LEAD: begin
            if (!blank) begin
               nx.phase       = cdr_pkg::PH_TYPE;
               grow           = 1'b1;
               grow_from_zero = 1'b1;
               type_check     = 1'b1;
            end
         end
         cdr_pkg::PH_TYPE: begin
            if (cdr_pkg::is_sep_blank(c)) begin
               if (!state.saw_letter)
                  nx.rejected = 1'b1;
               nx.phase = cdr_pkg::PH_SEP;
            end else begin
               grow       = 1'b1;
               type_check = 1'b1;
            end
         end
         cdr_pkg::PH_SEP: begin
            if (cdr_pkg::is_mark(c)) begin
               nx.phase      = cdr_pkg::PH_MARKS;
               nx.mark_count = 2'd1;
            end else if (!cdr_pkg::is_sep_blank(c)) begin
               nx.rejected = 1'b1;
            end
         end
         cdr_pkg::PH_MARKS: begin
            if (cdr_pkg::is_mark(c)) begin
               if (state.mark_count >= 2'd2)
                  nx.rejected = 1'b1;
               else
                  nx.mark_count = state.mark_count + 2'd1;
            end else if (blank) begin
               nx.phase = cdr_pkg::PH_GAP;
            end else if (cdr_pkg::is_ident_start(c)) begin
               nx.phase       = cdr_pkg::PH_IDENT;
               grow           = 1'b1;
               grow_from_zero = 1'b1;
            end else begin
               nx.rejected = 1'b1;
            end
         end
         cdr_pkg::PH_GAP: begin
            if (!blank) begin
               if (cdr_pkg::is_ident_start(c)) begin
                  nx.phase       = cdr_pkg::PH_IDENT;
                  grow           = 1'b1;
                  grow_from_zero = 1'b1;
               end else begin
                  nx.rejected = 1'b1;
               end
            end
         end
         cdr_pkg::PH_IDENT: begin
            if (blank)
               nx.phase = cdr_pkg::PH_TRAIL;
            else if (cdr_pkg::is_ident_char(c))
               grow = 1'b1;
            else
               nx.rejected = 1'b1;
         end
         default: begin
            if (!blank)
               nx.rejected = 1'b1;
         end
      endcase

      if (type_check) begin
         if (cdr_pkg::is_letter(c))
            nx.saw_letter = 1'b1;
         else if (!(cdr_pkg::is_digit(c) || c == cdr_pkg::CH_UNDER ||
                    c == cdr_pkg::CH_COLON || c == cdr_pkg::CH_LT ||
                    c == cdr_pkg::CH_GT))
            nx.rejected = 1'b1;
      end

      if (grow) begin
         tok_new         = grow_from_zero ? 7'd1 : cdr_pkg::sat_inc(state.token_length);
         nx.token_length = tok_new;
         if (tok_new > cfg.max_token_length)
            nx.rejected = 1'b1;
      end

      nx.previous_byte = c;
   end

   assign ok = !nx.rejected &&
               (nx.phase == cdr_pkg::PH_IDENT || nx.phase == cdr_pkg::PH_TRAIL) &&
               (nx.trimmed_length >= cfg.min_fragment_length) &&
               (nx.trimmed_length <= cfg.max_fragment_length) &&
               (nx.mark_count >= 2'd1) && (nx.mark_count <= 2'd2);

   always_comb begin
      rsp.is_declaration     = ok;
      rsp.pointer_level      = ok ? nx.mark_count : 2'd0;
      rsp.confidence_percent = !ok ? 7'd0 :
                               (nx.mark_count == 2'd2) ? cdr_pkg::CONF_TWO_MARKS :
                                                         cdr_pkg::CONF_ONE_MARK;
   end

   // Start over after the final byte of a fragment
   assign state_nxt = req.last ? cdr_pkg::STATE_RST : nx;

endmodule

`default_nettype wire

/* rtl/cpp_declaration_recognizer_unit.sv */
// ---------------------------------------------------------------------------
// cpp_declaration_recognizer_unit: streaming pointer/reference decl check
// Input register, one-byte parse step, result register.
// ---------------------------------------------------------------------------
// A final byte's verdict passes the input register and the result register to rsp_valid.
// Throughput: one byte per cycle while a final byte is not held by a full result register.
// Results appear only for bytes marked last; rsp_ready stalls back to req_ready.
// Reset (synchronous): clears parse state and both valid flags; limits return
// to 6, 96 and 64.
`default_nettype none

module cpp_declaration_recognizer_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire cdr_pkg::cdr_req_type      req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output cdr_pkg::cdr_rsp_type           rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [cdr_pkg::LEN_W-1:0] csr_data
);

   cdr_pkg::cdr_cfg_type   cfg;
   cdr_pkg::cdr_req_type   in_ff;
   logic                   in_vld_ff;
   cdr_pkg::cdr_state_type state_ff, state_in;
   cdr_pkg::cdr_rsp_type   rsp_ff, rsp_in;
   logic                   rsp_vld_ff;
   logic                   out_free;
   logic                   advance;

   cdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cdr_step u_step (
      .state     (state_ff),
      .cfg       (cfg),
      .req       (in_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   assign out_free  = !rsp_vld_ff || rsp_ready;
   // A non-final byte never needs the result register
   assign advance   = in_vld_ff && (!in_ff.last || out_free);
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= cdr_pkg::STATE_RST;
      end else begin
         if (req_ready)
            in_vld_ff <= req_valid;
         if (advance)
            state_ff <= state_in;
         if (advance && in_ff.last)
            rsp_vld_ff <= 1'b1;
         else if (rsp_ready)
            rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid)
         in_ff <= req_data;
      if (advance && in_ff.last)
         rsp_ff <= rsp_in;
   end

   // Each final byte returns the parser to its starting point
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.last |=> state_ff.phase == cdr_pkg::PH_LEAD &&
                                state_ff.trimmed_length == '0 && !state_ff.rejected)
      else $error("parse state not cleared after final byte");

   // Hold a stalled byte in the input register
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_ff))
      else $error("stalled input byte lost or changed");

   a_marks_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.mark_count != 2'd3)
      else $error("mark count out of range");

   a_verdict_level: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_ff.is_declaration == (rsp_ff.pointer_level != 2'd0))
      else $error("verdict and pointer level disagree");

   a_verdict_conf: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.is_declaration && rsp_ff.pointer_level == 2'd1 &&
                      rsp_ff.confidence_percent == cdr_pkg::CONF_ONE_MARK) ||
                     (rsp_ff.is_declaration && rsp_ff.pointer_level == 2'd2 &&
                      rsp_ff.confidence_percent == cdr_pkg::CONF_TWO_MARKS) ||
                     (!rsp_ff.is_declaration && rsp_ff.confidence_percent == 7'd0))
      else $error("confidence does not match verdict");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: regression for cpp_declaration_recognizer_unit
// Streams text fragments byte by byte through the request channel. A local
// parser model predicts each fragment's verdict, and every response is
// compared field by field in arrival order. The register port is exercised at
// its limits, and both channels idle and stall at random.
// ---------------------------------------------------------------------------

module testbench;
   import cdr_pkg::*;

   localparam logic [1:0] CSR_SPARE_IDX = 2'd3;
   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [7:0] BLANK_SET [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};
   localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam string DIGITS = "0123456789";

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   cdr_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   cdr_rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [LEN_W-1:0] csr_data;

   // parser model: limits and per-fragment scan state
   cdr_cfg_type limits;
   cdr_state_type scan;
   cdr_rsp_type pending_verdicts[$];
   logic [7:0] frag_buf[$];

   int mismatch_count = 0;
   int send_gap_max = 3;
   int recv_gap_max = 3;
   int rsp_hold_cycles = 0;

   cpp_declaration_recognizer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- byte classes ----------------
   function automatic bit trim_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit sep_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic bit alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit ptr_mark(input logic [7:0] c);
      return c == CH_AMP || c == CH_STAR;
   endfunction

   function automatic bit name_head(input logic [7:0] c);
      return alpha(c) || c == CH_UNDER;
   endfunction

   function automatic bit banned(input logic [7:0] c);
      return c == "{" || c == "}" || c == "[" || c == "]" || c == "(" ||
             c == ")" || c == ";" || c == CH_EQ || c == ",";
   endfunction

   function automatic logic [LEN_W-1:0] clip_add(input int a, input int b);
      int s;
      s = a + b;
      return (s > int'(LEN_SAT)) ? LEN_SAT : LEN_W'(s);
   endfunction

   // ---------------- parser model ----------------
   function automatic void bump_token();
      scan.token_length = clip_add(scan.token_length, 1);
      if (scan.token_length > limits.max_token_length)
         scan.rejected = 1'b1;
   endfunction

   function automatic void take_type_char(input logic [7:0] c);
      if (alpha(c))
         scan.saw_letter = 1'b1;
      else if (!(numeral(c) || c == CH_UNDER || c == CH_COLON || c == CH_LT || c == CH_GT))
         scan.rejected = 1'b1;
      bump_token();
   endfunction

   function automatic void open_ident(input logic [7:0] c);
      if (name_head(c)) begin
         scan.phase = PH_IDENT;
         scan.token_length = '0;
         bump_token();
      end else begin
         scan.rejected = 1'b1;
      end
   endfunction

   // Advance the scan by one byte; on the closing byte return 1 with the verdict.
   function automatic bit parse_step(input logic [7:0] c, input logic last,
                                     output cdr_rsp_type verdict);
      bit blank;
      bit ok;
      blank = trim_space(c);
      verdict = '0;
      if (banned(c))
         scan.rejected = 1'b1;
      if ((scan.previous_byte == CH_COLON && c == CH_COLON) ||
          (scan.previous_byte == CH_DASH && c == CH_GT) ||
          (scan.previous_byte == CH_EQ && c == CH_GT))
         scan.rejected = 1'b1;

      // trailing blanks only count once a later non-blank closes them
      if (scan.phase != PH_LEAD || !blank) begin
         if (blank) begin
            scan.trailing_blank_run = clip_add(scan.trailing_blank_run, 1);
         end else begin
            scan.trimmed_length = clip_add(scan.trimmed_length,
                                           clip_add(scan.trailing_blank_run, 1));
            scan.trailing_blank_run = '0;
         end
      end

      case (scan.phase)
         PH_LEAD: begin
            if (!blank) begin
               scan.phase = PH_TYPE;
               scan.token_length = '0;
               take_type_char(c);
            end
         end
         PH_TYPE: begin
            if (sep_space(c)) begin
               if (!scan.saw_letter)
                  scan.rejected = 1'b1;
               scan.phase = PH_SEP;
            end else begin
               take_type_char(c);
            end
         end
         PH_SEP: begin
            if (ptr_mark(c)) begin
               scan.phase = PH_MARKS;
               scan.mark_count = 2'd1;
            end else if (!sep_space(c)) begin
               scan.rejected = 1'b1;
            end
         end
         PH_MARKS: begin
            if (ptr_mark(c)) begin
               if (scan.mark_count >= 2'd2)
                  scan.rejected = 1'b1;
               else
                  scan.mark_count = scan.mark_count + 2'd1;
            end else if (blank) begin
               scan.phase = PH_GAP;
            end else begin
               open_ident(c);
            end
         end
         PH_GAP: begin
            if (!blank)
               open_ident(c);
         end
         PH_IDENT: begin
            if (blank)
               scan.phase = PH_TRAIL;
            else if (name_head(c) || numeral(c))
               bump_token();
            else
               scan.rejected = 1'b1;
         end
         default: begin
            if (!blank)
               scan.rejected = 1'b1;
         end
      endcase

      scan.previous_byte = c;
      if (!last)
         return 1'b0;

      ok = !scan.rejected && (scan.phase == PH_IDENT || scan.phase == PH_TRAIL) &&
           scan.trimmed_length >= limits.min_fragment_length &&
           scan.trimmed_length <= limits.max_fragment_length &&
           scan.mark_count >= 2'd1 && scan.mark_count <= 2'd2;
      if (ok) begin
         verdict.is_declaration = 1'b1;
         verdict.pointer_level = scan.mark_count;
         verdict.confidence_percent = (scan.mark_count == 2'd2) ? CONF_TWO_MARKS
                                                                 : CONF_ONE_MARK;
      end
      scan = STATE_RST;
      return 1'b1;
   endfunction

   // ---------------- channel drivers ----------------
   // Entered and left just after a falling edge; valid stays high on exit so a
   // back-to-back byte keeps it up without a second assignment.
   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      cdr_rsp_type verdict;
      gap = $urandom_range(send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{ch: c, last: last};
      do @(posedge clock); while (req_ready !== 1'b1);
      if (parse_step(c, last, verdict))
         pending_verdicts.push_back(verdict);
      @(negedge clock);
   endtask

   task automatic send_frag();
      for (int i = 0; i < frag_buf.size(); i++)
         send_byte(frag_buf[i], i == frag_buf.size() - 1);
      frag_buf.delete();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         frag_buf.push_back(s[i]);
      send_frag();
   endtask

   // Drop valid, wait for every verdict, then let the pipeline empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_MIN_FRAG_LEN: limits.min_fragment_length = val;
         CSR_MAX_FRAG_LEN: limits.max_fragment_length = val;
         CSR_MAX_TOK_LEN:  limits.max_token_length = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_limits(input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] hi,
                             input logic [LEN_W-1:0] tok);
      settle();
      write_reg(CSR_MIN_FRAG_LEN, lo);
      write_reg(CSR_MAX_FRAG_LEN, hi);
      write_reg(CSR_MAX_TOK_LEN, tok);
      csr_valid <= 1'b0;
   endtask

   // ---------------- fragment builders ----------------
   function automatic logic [7:0] pick(input string pool);
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   function automatic void put_blanks(input int n, input bit sep_only);
      repeat (n) frag_buf.push_back(BLANK_SET[$urandom_range(sep_only ? 3 : 5)]);
   endfunction

   function automatic int pick_token_len();
      return ($urandom_range(19) == 0) ? $urandom_range(140, 20) : $urandom_range(8, 1);
   endfunction

   function automatic void put_type_token(input int n);
      int spot;
      spot = $urandom_range(n - 1);
      for (int i = 0; i < n; i++) begin
         if (i == spot)
            frag_buf.push_back(pick(LETTERS));
         else if ($urandom_range(9) == 0)
            frag_buf.push_back(pick("_:<>0123456789"));
         else
            frag_buf.push_back(pick({LETTERS, DIGITS}));
      end
   endfunction

   function automatic void put_ident(input int n);
      frag_buf.push_back(pick({LETTERS, "_"}));
      repeat (n - 1) frag_buf.push_back(pick({LETTERS, DIGITS, "_"}));
   endfunction

   function automatic void build_decl();
      put_blanks($urandom_range(2), 1'b0);
      put_type_token(pick_token_len());
      put_blanks($urandom_range(2, 1), 1'b1);
      repeat (($urandom_range(15) == 0) ? 3 : $urandom_range(2, 1))
         frag_buf.push_back(pick("&*"));
      put_blanks($urandom_range(2), 1'b0);
      put_ident(pick_token_len());
      put_blanks($urandom_range(2), 1'b0);
   endfunction

   function automatic void build_random_fragment();
      int roll;
      int spot;
      roll = $urandom_range(99);
      if (roll < 85) begin
         build_decl();
         // break a well-formed fragment with one stray byte
         if (roll >= 70) begin
            spot = $urandom_range(frag_buf.size() - 1);
            if ($urandom_range(1))
               frag_buf[spot] = 8'($urandom_range(255));
            else
               frag_buf[spot] = pick("{}[]();=,:->*& ");
         end
      end else begin
         repeat ($urandom_range(6, 1)) frag_buf.push_back(8'($urandom_range(255)));
      end
   endfunction

   // ---------------- response side ----------------
   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(recv_gap_max);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      cdr_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $error("response transfer with no verdict pending");
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.is_declaration !== want.is_declaration) begin
               $error("is_declaration: expected %0d, got %0d",
                      want.is_declaration, rsp_data.is_declaration);
               mismatch_count++;
            end
            if (rsp_data.pointer_level !== want.pointer_level) begin
               $error("pointer_level: expected %0d, got %0d",
                      want.pointer_level, rsp_data.pointer_level);
               mismatch_count++;
            end
            if (rsp_data.confidence_percent !== want.confidence_percent) begin
               $error("confidence_percent: expected %0d, got %0d",
                      want.confidence_percent, rsp_data.confidence_percent);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------- tests ----------------
   task automatic check_directed_fragments();
      send_text("int *p");
      send_text("Foo<int> &&x");
      send_text("  std:vector<T> *  v  ");
      send_text("int\t\r\n*&p");
      send_text("int * p");
      send_text("int *abc_9 \t");
      send_text("int ***p");
      send_text("int *p;");
      send_text("a::b *p");
      send_text("x->y *p");
      send_text("x=>y *p");
      send_text("int * *p");
      send_text("123 *p");
      send_text("int *9p");
      send_text("int *");
      send_text("i *p");
      send_text(" ");
      // vertical tab inside the type, form feed before the marks
      frag_buf = '{"i", "n", CH_VT, "t", " ", "*", "p"};
      send_frag();
      frag_buf = '{"i", "n", "t", CH_FF, "*", "p"};
      send_frag();
      frag_buf.push_back(8'h00);
      send_frag();
      frag_buf = '{"i", "n", "t", " ", "*", "p", 8'hFF};
      send_frag();
      frag_buf = '{"i", "n", "t", " ", "*", "p", 8'h80};
      send_frag();
   endtask

   task automatic check_register_limits();
      // widest window: length counters saturate and a 150-byte type still passes
      set_limits(7'd0, 7'd127, 7'd127);
      send_text("a *b");
      repeat (150) frag_buf.push_back("a");
      send_text(" *x");
      set_limits(7'd127, 7'd127, 7'd127);
      repeat (130) frag_buf.push_back("T");
      send_text(" &&y");
      send_text("int *p");
      set_limits(7'd0, 7'd0, 7'd1);
      send_text("a *b");
      set_limits(7'd0, 7'd96, 7'd1);
      send_text("a *b");
      send_text("ab *c");
      send_text("a *bc");
      // limits out of order and a zero token limit reject everything
      set_limits(7'd10, 7'd5, 7'd64);
      send_text("int *abcd");
      set_limits(7'd6, 7'd96, 7'd0);
      send_text("a *b");
      set_limits(MIN_FRAG_LEN_RST, MAX_FRAG_LEN_RST, MAX_TOK_LEN_RST);
      repeat (70) frag_buf.push_back("z");
      send_text(" *q");
      // an unused index must leave the limits alone
      settle();
      write_reg(CSR_SPARE_IDX, 7'd0);
      csr_valid <= 1'b0;
      send_text("int *p");
   endtask

   task automatic check_random_fragments();
      int sent;
      for (int pass_idx = 0; pass_idx < 5; pass_idx++) begin
         case (pass_idx)
            0: begin
               set_limits(MIN_FRAG_LEN_RST, MAX_FRAG_LEN_RST, MAX_TOK_LEN_RST);
               send_gap_max = 0;
               recv_gap_max = 0;
            end
            1: begin
               set_limits(7'($urandom_range(8)), 7'($urandom_range(127, 30)),
                          7'($urandom_range(127, 4)));
               send_gap_max = 11;
               recv_gap_max = 11;
            end
            2: begin
               set_limits(7'($urandom_range(8)), 7'($urandom_range(127, 30)),
                          7'($urandom_range(127, 4)));
               send_gap_max = 3;
               recv_gap_max = 0;
            end
            3: begin
               set_limits(7'd0, 7'd127, 7'd127);
               send_gap_max = 0;
               recv_gap_max = 11;
            end
            default: begin
               set_limits(7'($urandom_range(1) * 127), 7'($urandom_range(1) * 127),
                          $urandom_range(1) ? 7'd127 : 7'd1);
               send_gap_max = 11;
               recv_gap_max = 3;
            end
         endcase
         sent = 0;
         while (sent < 16) begin
            build_random_fragment();
            sent += frag_buf.size();
            send_frag();
         end
      end
   endtask

   task automatic check_result_backpressure();
      set_limits(MIN_FRAG_LEN_RST, MAX_FRAG_LEN_RST, MAX_TOK_LEN_RST);
      send_gap_max = 0;
      recv_gap_max = 0;
      // hold the response side long enough to back up the request side
      rsp_hold_cycles = 150;
      repeat (12) begin
         if ($urandom_range(3) == 0)
            build_decl();
         else
            frag_buf.push_back(8'($urandom_range(255)));
         send_frag();
      end
      settle();
      send_gap_max = 3;
      recv_gap_max = 3;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      limits = '{MIN_FRAG_LEN_RST, MAX_FRAG_LEN_RST, MAX_TOK_LEN_RST};
      scan = STATE_RST;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_directed_fragments();
      check_register_limits();
      check_random_fragments();
      check_result_backpressure();

      req_valid <= 1'b0;
      for (int k = 0; k < 4000 && pending_verdicts.size() != 0; k++)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", pending_verdicts.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
